FILE: src/lock_order_checker_macros.svh
// ============================================================================
// Lock order checker assertion macros
// Concurrent assertion shorthands on clk with rst_n as the disable.
// ============================================================================
`ifndef LOCK_ORDER_CHECKER_MACROS_SVH
`define LOCK_ORDER_CHECKER_MACROS_SVH

// same-cycle implication
`define LOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/loc_pkg.sv
// ============================================================================
// Lock order checker package
// Beat types, function codes and status codes.
// ============================================================================
package loc_pkg;

    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_IGNORED      = 3'd1;
    localparam logic [2:0] ST_REENTRANT    = 3'd2;
    localparam logic [2:0] ST_OUT_OF_ORDER = 3'd3;
    localparam logic [2:0] ST_RELEASE_EMPTY = 3'd4;
    localparam logic [2:0] ST_UNBALANCED   = 3'd5;
    localparam logic [2:0] ST_OVERFLOW     = 3'd6;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] thread_id;
        logic [3:0] lock_cls;
    } loc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  held_class;
        logic [31:0] viol_total;
        logic [4:0]  held_depth;
    } loc_out_t;

endpackage

FILE: src/loc_ram.sv
// ============================================================================
// Lock order checker RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ============================================================================
module loc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/lock_order_checker.sv
// ============================================================================
// Lock order checker
// Per-thread held-lock stacks in RAM with order, balance and overflow checks.
// ----------------------------------------------------------------------------
//   channel   direction  signals                         beat
//   in        input      in_valid  in_ready  in_data     one event
//   out       output     out_valid out_ready out_data    one result
//   cfg       input      cfg_valid cfg_ready cfg_data    tracking enable
//
// One event passes three steps: accept with the depth RAM read, the stack RAM
// read at the top entry, then check and write back. The two chained RAM
// reads set these steps. Reset clears the depth valid bits, the counter and
// sets tracking on; the stack RAM is not cleared. The write back waits while
// an earlier result beat is still held on out.
// ============================================================================
`include "lock_order_checker_macros.svh"

module lock_order_checker #(
    parameter int THREADS = 8,
    parameter int DEPTH   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  loc_pkg::loc_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output loc_pkg::loc_out_t out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int DW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(THREADS * DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_DEPTH, S_TOP} state_t;

    state_t             state_reg, state_next;
    loc_pkg::loc_in_t   req_reg, req_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [THREADS-1:0] dvalid_reg, dvalid_next;
    logic [31:0]        viol_reg, viol_next;
    logic               track_reg, track_next;
    logic               out_valid_reg, out_valid_next;
    loc_pkg::loc_out_t  out_data_reg, out_data_next;

    logic [TW-1:0] tid_idx;
    logic [TW-1:0] dep_raddr;
    logic [DW-1:0] dep_rdata;
    logic [DW-1:0] dep_fresh;
    logic [DW-1:0] dep_cur;
    logic [AW-1:0] base;
    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] stk_waddr;
    logic [3:0]    stk_rdata;
    logic          in_range;
    logic          out_free;
    logic          commit;
    logic          push;
    logic          dep_we;
    logic          stk_we;
    logic [3:0]    top;
    logic [2:0]    status;
    logic [DW-1:0] depth_new;
    logic [1:0]    n_viol;
    logic          active;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign tid_idx   = TW'(req_reg.thread_id);
    assign in_range  = (32'(req_reg.thread_id) < THREADS);
    assign dep_raddr = (state_reg == S_IDLE) ? TW'(in_data.thread_id) : tid_idx;
    assign dep_fresh = dvalid_reg[tid_idx] ? dep_rdata : '0;
    assign dep_cur   = (state_reg == S_DEPTH) ? dep_fresh : depth_reg;
    assign base      = AW'(AW'(tid_idx) * AW'(DEPTH));
    assign stk_raddr = AW'(base + AW'(dep_cur) - AW'(1));
    assign stk_waddr = AW'(base + AW'(depth_reg));
    assign out_free  = !out_valid_reg || out_ready;
    assign commit    = (state_reg == S_TOP) && out_free;
    assign top       = (in_range && depth_reg != '0) ? stk_rdata : 4'd0;
    assign active    = in_range && track_reg && (req_reg.lock_cls != 4'd0)
                       && (req_reg.func == loc_pkg::FUNC_ACQUIRE
                           || req_reg.func == loc_pkg::FUNC_RELEASE);

    always_comb
    begin
        status    = loc_pkg::ST_IGNORED;
        depth_new = depth_reg;
        n_viol    = 2'd0;
        push      = 1'b0;
        if (!in_range)
        begin
            depth_new = '0;
        end
        else if (req_reg.func == loc_pkg::FUNC_CLEAR)
        begin
            status    = loc_pkg::ST_OK;
            depth_new = '0;
        end
        else if (active && req_reg.func == loc_pkg::FUNC_ACQUIRE)
        begin
            status = loc_pkg::ST_OK;
            if (depth_reg != '0)
            begin
                if (req_reg.lock_cls == top)
                begin
                    status = loc_pkg::ST_REENTRANT;
                    n_viol = 2'd1;
                end
                else if (req_reg.lock_cls < top)
                begin
                    status = loc_pkg::ST_OUT_OF_ORDER;
                    n_viol = 2'd1;
                end
            end
            if (depth_reg >= DW'(DEPTH))
            begin
                status = loc_pkg::ST_OVERFLOW;
                n_viol = n_viol + 2'd1;
            end
            else
            begin
                push      = 1'b1;
                depth_new = DW'(depth_reg + DW'(1));
            end
        end
        else if (active)
        begin
            if (depth_reg == '0)
            begin
                status = loc_pkg::ST_RELEASE_EMPTY;
                n_viol = 2'd1;
            end
            else
            begin
                status = loc_pkg::ST_OK;
                if (req_reg.lock_cls != top)
                begin
                    status = loc_pkg::ST_UNBALANCED;
                    n_viol = 2'd1;
                end
                depth_new = DW'(depth_reg - DW'(1));
            end
        end
    end

    assign dep_we = commit && in_range;
    assign stk_we = commit && push;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        depth_next     = depth_reg;
        dvalid_next    = dvalid_reg;
        viol_next      = viol_reg;
        track_next     = track_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid)
        begin
            track_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_DEPTH;
                end
            end
            S_DEPTH:
            begin
                depth_next = dep_fresh;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                if (out_free)
                begin
                    if (in_range && req_reg.func == loc_pkg::FUNC_CLEAR)
                    begin
                        viol_next = '0;
                    end
                    else if (viol_reg > loc_pkg::COUNT_MAX - 32'(n_viol))
                    begin
                        viol_next = loc_pkg::COUNT_MAX;
                    end
                    else
                    begin
                        viol_next = viol_reg + 32'(n_viol);
                    end
                    if (dep_we)
                    begin
                        dvalid_next[tid_idx] = 1'b1;
                    end
                    out_valid_next           = 1'b1;
                    out_data_next.status     = status;
                    out_data_next.held_class = top;
                    out_data_next.viol_total = viol_next;
                    out_data_next.held_depth = 5'(depth_new);
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            depth_reg     <= '0;
            dvalid_reg    <= '0;
            viol_reg      <= '0;
            track_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            depth_reg     <= depth_next;
            dvalid_reg    <= dvalid_next;
            viol_reg      <= viol_next;
            track_reg     <= track_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    loc_ram #(
        .WIDTH (DW),
        .DEPTH (THREADS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (tid_idx),
        .wdata (depth_new),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    loc_ram #(
        .WIDTH (4),
        .DEPTH (THREADS * DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (req_reg.lock_cls),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    `LOC_ASSERT_NEXT(a_accept_to_depth, in_valid && in_ready, state_reg == S_DEPTH,
        "accepted event did not move to depth read")
    `LOC_ASSERT_NOW(a_depth_bound, dep_we, depth_new <= DW'(DEPTH),
        "depth written above stack size")
    `LOC_ASSERT_NOW(a_push_room, stk_we, in_range && depth_reg < DW'(DEPTH),
        "push written on full stack or bad thread")
    `LOC_ASSERT_NOW(a_count_monotonic, commit && req_reg.func != loc_pkg::FUNC_CLEAR,
        viol_next >= viol_reg, "violation count decreased without clear")

endmodule
